// File: rtl/bba_pkg.sv
// Shared constants, types and helper functions of the binary buddy allocator.
// No dependencies; bba_dp, bba_ctrl, the top level and the testbench import this package.
package bba_pkg;

    localparam int MIN_BLOCK_BITS = 4;
    localparam int LEVELS         = 8;

    localparam int NODE_COUNT   = 1 << LEVELS;
    localparam int MIN_COUNT    = 1 << (LEVELS - 1);
    localparam int REGION_BYTES = 1 << (MIN_BLOCK_BITS + LEVELS - 1);

    localparam int NODE_W  = LEVELS;
    localparam int IDX_W   = LEVELS - 1;
    localparam int LV_W    = $clog2(LEVELS + 1);
    localparam int LVRAM_W = 4;
    localparam int ADDR_W  = 32;
    localparam int SIZE_W  = 12;
    localparam int USED_W  = 12;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_SIZE = 2'd1;
    localparam logic [1:0] ST_NO_FIT   = 2'd2;
    localparam logic [1:0] ST_BAD_ADDR = 2'd3;

    typedef struct packed {
        logic       capture;
        logic       alloc_init;
        logic       search;
        logic       split;
        logic       free_load;
        logic       merge;
        logic       out_load;
        logic [1:0] out_status;
    } t_cmd;

    typedef struct packed {
        logic size_bad;
        logic lv_end;
        logic hit;
        logic split_more;
        logic addr_bad;
        logic merge_more;
    } t_sts;

    // bytes of one block at a level
    function automatic logic [ADDR_W-1:0] level_bytes(input int lv);
        level_bytes = ADDR_W'(1) << (MIN_BLOCK_BITS + lv);
    endfunction

    // heap index of the leftmost node of a level
    function automatic logic [NODE_W-1:0] first_node(input int lv);
        first_node = NODE_W'(1) << (LEVELS - 1 - lv);
    endfunction

    // marks the nodes that belong to one level
    function automatic logic [NODE_COUNT-1:0] level_mask(input int lv);
        logic [NODE_COUNT-1:0] m;
        m = '0;
        if (lv < LEVELS) begin
            for (int n = 0; n < NODE_COUNT; n++) begin
                m[n] = ((n >> (LEVELS - 1 - lv)) == 1);
            end
        end
        level_mask = m;
    endfunction

endpackage

// File: rtl/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bba_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/bba_dp.sv
// Datapath: free bitmap, allocation valid bits, level RAM, counters and result registers.
// Depends on bba_pkg and bba_ram.
module bba_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bba_pkg::t_cmd              i_cmd,
    output bba_pkg::t_sts              o_sts,
    input  logic                       i_cfg_valid,
    input  logic [31:0]                i_cfg_data,
    input  logic [bba_pkg::SIZE_W-1:0] i_request_size,
    input  logic [bba_pkg::ADDR_W-1:0] i_free_address,
    output logic [1:0]                 o_status,
    output logic [bba_pkg::ADDR_W-1:0] o_block_address,
    output logic [bba_pkg::USED_W-1:0] o_used_bytes
);
    import bba_pkg::*;

    logic [ADDR_W-1:0]     r_base;
    logic [SIZE_W-1:0]     r_size;
    logic [ADDR_W-1:0]     r_addr;
    logic [NODE_COUNT-1:0] r_free, n_free;
    logic [MIN_COUNT-1:0]  r_valid, n_valid;
    logic [LV_W-1:0]       r_lv, n_lv;
    logic [LV_W-1:0]       r_need, n_need;
    logic [NODE_W-1:0]     r_node, n_node;
    logic [USED_W-1:0]     r_used, n_used;
    logic [1:0]            r_st;
    logic [ADDR_W-1:0]     r_out_addr;
    logic [USED_W-1:0]     r_out_used;

    logic [LV_W-1:0]       need_c;
    logic                  size_bad;
    logic [NODE_COUNT-1:0] masked;
    logic                  hit;
    logic [NODE_W-1:0]     hit_node;
    logic [ADDR_W-1:0]     off;
    logic [IDX_W-1:0]      free_idx;
    logic [IDX_W-1:0]      alloc_idx;
    logic [NODE_W-1:0]     alloc_i;
    logic [ADDR_W-1:0]     alloc_addr;
    logic [LVRAM_W-1:0]    ram_rdata;
    logic [LV_W-1:0]       ram_lv;
    logic                  split_more;
    logic                  merge_more;
    logic                  alloc_fin;

    always_comb begin
        size_bad = (r_size == '0) || ({{(ADDR_W-SIZE_W){1'b0}}, r_size} > ADDR_W'(REGION_BYTES));
        need_c   = '0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (level_bytes(l) >= {{(ADDR_W-SIZE_W){1'b0}}, r_size}) begin
                need_c = LV_W'(l);
            end
        end
    end

    // lowest-address free node of the level under search
    always_comb begin
        masked   = r_free & level_mask(int'(r_lv));
        hit      = 1'b0;
        hit_node = '0;
        for (int n = NODE_COUNT - 1; n >= 0; n--) begin
            if (masked[n]) begin
                hit      = 1'b1;
                hit_node = NODE_W'(n);
            end
        end
    end

    assign off       = r_addr - r_base;
    assign free_idx  = off[MIN_BLOCK_BITS +: IDX_W];
    assign alloc_i   = r_node - first_node(int'(r_need));
    assign alloc_idx = IDX_W'({{(IDX_W){1'b0}}, alloc_i} << r_need);
    assign alloc_addr = r_base + {{(ADDR_W-IDX_W-MIN_BLOCK_BITS){1'b0}}, alloc_idx,
                                  {MIN_BLOCK_BITS{1'b0}}};
    assign ram_lv    = LV_W'(ram_rdata);

    assign split_more = (r_lv > r_need);
    assign merge_more = (r_lv < LV_W'(LEVELS - 1)) && r_free[r_node ^ NODE_W'(1)];
    assign alloc_fin  = i_cmd.split && !split_more;

    bba_ram #(
        .WIDTH(LVRAM_W),
        .DEPTH(MIN_COUNT)
    ) u_lvl_ram (
        .i_clk  (i_clk),
        .i_we   (alloc_fin),
        .i_waddr(alloc_idx),
        .i_wdata(LVRAM_W'(r_need)),
        .i_raddr(free_idx),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_free  = r_free;
        n_valid = r_valid;
        n_lv    = r_lv;
        n_need  = r_need;
        n_node  = r_node;
        n_used  = r_used;
        if (i_cmd.alloc_init) begin
            n_need = need_c;
            n_lv   = need_c;
        end
        if (i_cmd.search) begin
            if (hit) begin
                n_node           = hit_node;
                n_free[hit_node] = 1'b0;
            end else begin
                n_lv = r_lv + LV_W'(1);
            end
        end
        if (i_cmd.split) begin
            if (split_more) begin
                // keep the left half, free the right one
                n_node = r_node << 1;
                n_lv   = r_lv - LV_W'(1);
                n_free[(r_node << 1) | NODE_W'(1)] = 1'b1;
            end else begin
                n_valid[alloc_idx] = 1'b1;
                n_used = r_used + USED_W'(level_bytes(int'(r_need)));
            end
        end
        if (i_cmd.free_load) begin
            n_lv              = ram_lv;
            n_valid[free_idx] = 1'b0;
            n_used = r_used - USED_W'(level_bytes(int'(ram_lv)));
            n_node = first_node(int'(ram_lv))
                   + NODE_W'({{(NODE_W-IDX_W){1'b0}}, free_idx} >> ram_lv);
        end
        if (i_cmd.merge) begin
            if (merge_more) begin
                n_free[r_node ^ NODE_W'(1)] = 1'b0;
                n_node = r_node >> 1;
                n_lv   = r_lv + LV_W'(1);
            end else begin
                n_free[r_node] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_free  <= NODE_COUNT'(2);
            r_valid <= '0;
            r_used  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_base <= i_cfg_data;
            end
            r_free  <= n_free;
            r_valid <= n_valid;
            r_used  <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_size <= i_request_size;
            r_addr <= i_free_address;
        end
        r_lv   <= n_lv;
        r_need <= n_need;
        r_node <= n_node;
        if (i_cmd.out_load) begin
            r_st       <= i_cmd.out_status;
            r_out_addr <= alloc_fin ? alloc_addr : '0;
            r_out_used <= n_used;
        end
    end

    always_comb begin
        o_sts.size_bad   = size_bad;
        o_sts.lv_end     = (r_lv >= LV_W'(LEVELS));
        o_sts.hit        = hit;
        o_sts.split_more = split_more;
        o_sts.addr_bad   = (off >= ADDR_W'(REGION_BYTES))
                         || (off[MIN_BLOCK_BITS-1:0] != '0)
                         || !r_valid[free_idx];
        o_sts.merge_more = merge_more;
    end

    assign o_status        = r_st;
    assign o_block_address = r_out_addr;
    assign o_used_bytes    = r_out_used;
endmodule

// File: rtl/bba_ctrl.sv
// Controller: sequences the search, split and merge steps and owns the handshakes.
// Depends on bba_pkg.
module bba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic          i_kind,
    output logic          o_valid,
    input  logic          i_stall,
    output bba_pkg::t_cmd o_cmd,
    input  bba_pkg::t_sts i_sts
);
    import bba_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_ALLOC_CHK = 3'd1;
    localparam logic [2:0] S_SEARCH    = 3'd2;
    localparam logic [2:0] S_SPLIT     = 3'd3;
    localparam logic [2:0] S_FREE_CHK  = 3'd4;
    localparam logic [2:0] S_FREE_LD   = 3'd5;
    localparam logic [2:0] S_MERGE     = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_valid, n_valid;
    logic       accept;

    // a new item enters while idle, once the result slot is empty or draining
    assign o_stall = (r_state != S_IDLE) || (r_valid && i_stall);
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.capture = accept;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = i_kind ? S_FREE_CHK : S_ALLOC_CHK;
                end
            end
            S_ALLOC_CHK: begin
                if (i_sts.size_bad) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = ST_BAD_SIZE;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.alloc_init = 1'b1;
                    n_state          = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (i_sts.lv_end) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = ST_NO_FIT;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.search = 1'b1;
                    if (i_sts.hit) begin
                        n_state = S_SPLIT;
                    end
                end
            end
            S_SPLIT: begin
                o_cmd.split = 1'b1;
                if (!i_sts.split_more) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = ST_OK;
                    n_state          = S_IDLE;
                end
            end
            S_FREE_CHK: begin
                if (i_sts.addr_bad) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = ST_BAD_ADDR;
                    n_state          = S_IDLE;
                end else begin
                    n_state = S_FREE_LD;
                end
            end
            S_FREE_LD: begin
                o_cmd.free_load = 1'b1;
                n_state         = S_MERGE;
            end
            S_MERGE: begin
                o_cmd.merge = 1'b1;
                if (!i_sts.merge_more) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = ST_OK;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
        if (o_cmd.out_load) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_valid = r_valid;
endmodule

// File: rtl/binary_buddy_allocator_top.sv
// Binary buddy allocator: top level joining controller and datapath.
// Depends on bba_pkg, bba_ctrl and bba_dp.
//
// Usage:
//   Request channel i_valid/o_stall carries kind (0 allocate, 1 free), the
//   allocate size and the free address. Result channel o_valid/i_stall
//   returns status, block address and bytes in use, one result per request.
//   Configuration channel i_cfg_valid/o_cfg_ready writes the region base;
//   ready is always high, write only while no request is in flight.
// Sequencing:
//   One request is processed at a time. An allocate checks the size, then
//   searches the free bitmap level by level upward from the needed level,
//   then splits the found block down to it; a free checks the address, loads
//   the block's level from the level RAM, then merges with free buddies.
// Reset:
//   Synchronous, active low: only the whole region is free, no block is
//   allocated, bytes in use is zero, region base is zero.
// Back-pressure:
//   The result is held in an output register until taken; a new request is
//   accepted once the controller is idle and that register is empty or being emptied.
module binary_buddy_allocator_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_kind,
    input  logic [bba_pkg::SIZE_W-1:0] i_request_size,
    input  logic [bba_pkg::ADDR_W-1:0] i_free_address,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [1:0]                 o_status,
    output logic [bba_pkg::ADDR_W-1:0] o_block_address,
    output logic [bba_pkg::USED_W-1:0] o_used_bytes,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [31:0]                i_cfg_data
);
    import bba_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    bba_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_kind (i_kind),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_cmd  (cmd),
        .i_sts  (sts)
    );

    bba_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_request_size (i_request_size),
        .i_free_address (i_free_address),
        .o_status       (o_status),
        .o_block_address(o_block_address),
        .o_used_bytes   (o_used_bytes)
    );
endmodule

// File: test/testbench.sv
// Self-checking testbench of binary_buddy_allocator_top: allocate and free
// requests checked against a behavioral model of the buddy tree. Uses bba_pkg.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bba_pkg::*;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;
    localparam int   WATCHDOG   = 20000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic              i_kind = 1'b0;
    logic [SIZE_W-1:0] i_request_size = '0;
    logic [ADDR_W-1:0] i_free_address = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [1:0]        o_status;
    logic [ADDR_W-1:0] o_block_address;
    logic [USED_W-1:0] o_used_bytes;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [31:0]       i_cfg_data = '0;

    binary_buddy_allocator_top i_dut (.*);

    always #10 i_clk = ~i_clk;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] addr;
        logic [USED_W-1:0] used;
    } t_alloc_result;

    // model state
    logic [31:0]          base_reg;
    logic                 node_free [NODE_COUNT];
    logic                 start_valid [MIN_COUNT];
    logic [3:0]           start_level [MIN_COUNT];
    logic [31:0]          held_bytes;
    logic [ADDR_W-1:0]    live_addrs [$];
    t_alloc_result        pending_results [$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  idle_cycles = 0;
    bit  failed = 0;

    function automatic int lv_bytes(int lv);
        return 1 << (MIN_BLOCK_BITS + lv);
    endfunction

    function automatic int lv_first(int lv);
        return 1 << (LEVELS - 1 - lv);
    endfunction

    task automatic model_reset();
        base_reg = '0;
        foreach (node_free[n]) node_free[n] = 1'b0;
        node_free[1] = 1'b1;
        foreach (start_valid[n]) begin
            start_valid[n] = 1'b0;
            start_level[n] = '0;
        end
        held_bytes = 0;
        live_addrs.delete();
    endtask

    function automatic t_alloc_result predict_alloc(logic [SIZE_W-1:0] size);
        t_alloc_result r;
        int need, found, node, off, idx;
        r = '0;
        found = LEVELS;
        if (size == 0 || size > REGION_BYTES) begin
            r.status = ST_BAD_SIZE;
        end else begin
            need = 0;
            while (lv_bytes(need) < size) need++;
            for (int lv = need; lv < LEVELS && found == LEVELS; lv++) begin
                for (int i = 0; i < lv_first(lv); i++) begin
                    if (node_free[lv_first(lv) + i]) begin
                        found = lv;
                        node = lv_first(lv) + i;
                        break;
                    end
                end
            end
            if (found == LEVELS) begin
                r.status = ST_NO_FIT;
            end else begin
                node_free[node] = 1'b0;
                while (found > need) begin
                    node = node << 1;
                    found--;
                    node_free[node + 1] = 1'b1;
                end
                off = (node - lv_first(need)) << (MIN_BLOCK_BITS + need);
                idx = off >> MIN_BLOCK_BITS;
                start_valid[idx] = 1'b1;
                start_level[idx] = 4'(need);
                held_bytes += lv_bytes(need);
                r.status = ST_OK;
                r.addr = base_reg + 32'(off);
                live_addrs.push_back(r.addr);
            end
        end
        r.used = held_bytes[USED_W-1:0];
        return r;
    endfunction

    function automatic t_alloc_result predict_free(logic [ADDR_W-1:0] addr);
        t_alloc_result r;
        logic [31:0] off;
        int idx, lv, node;
        r = '0;
        off = addr - base_reg;
        idx = off >> MIN_BLOCK_BITS;
        if (off >= REGION_BYTES || off[MIN_BLOCK_BITS-1:0] != 0 || !start_valid[idx]) begin
            r.status = ST_BAD_ADDR;
        end else begin
            lv = start_level[idx];
            start_valid[idx] = 1'b0;
            start_level[idx] = '0;
            held_bytes -= lv_bytes(lv);
            node = lv_first(lv) + (off >> (MIN_BLOCK_BITS + lv));
            while (lv < LEVELS - 1 && node_free[node ^ 1]) begin
                node_free[node ^ 1] = 1'b0;
                node = node >> 1;
                lv++;
            end
            node_free[node] = 1'b1;
            r.status = ST_OK;
            foreach (live_addrs[k]) begin
                if (live_addrs[k] == addr) begin
                    live_addrs.delete(k);
                    break;
                end
            end
        end
        r.used = held_bytes[USED_W-1:0];
        return r;
    endfunction

    // drive one item and hold it until accepted; valid stays high for the next item
    task automatic send_request(logic kind, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_request_size <= size;
        i_free_address <= addr;
        do @(posedge i_clk); while (o_stall);
        if (kind == KIND_ALLOC) pending_results.push_back(predict_alloc(size));
        else                    pending_results.push_back(predict_free(addr));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2 * LEVELS + 4) @(posedge i_clk);
    endtask

    task automatic write_base(logic [31:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        base_reg = value;
    endtask

    always @(posedge i_clk) begin
        t_alloc_result exp_r;
        if (i_rst_n) begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result with no request outstanding");
                    failed = 1;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (o_status !== exp_r.status) begin
                        $error("status expected %0d got %0d", exp_r.status, o_status);
                        failed = 1;
                    end
                    if (o_block_address !== exp_r.addr) begin
                        $error("block_address expected %h got %h", exp_r.addr, o_block_address);
                        failed = 1;
                    end
                    if (o_used_bytes !== exp_r.used) begin
                        $error("used_bytes expected %0d got %0d", exp_r.used, o_used_bytes);
                        failed = 1;
                    end
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("FAIL binary_buddy_allocator_top");
                $finish;
            end
        end
    end

    task automatic free_all();
        while (live_addrs.size() != 0) send_request(KIND_FREE, '0, live_addrs[0]);
    endtask

    task automatic test_directed();
        send_request(KIND_ALLOC, 12'd0, '0);
        send_request(KIND_ALLOC, 12'(REGION_BYTES + 1), '0);
        send_request(KIND_ALLOC, 12'hFFF, '0);
        send_request(KIND_ALLOC, 12'(REGION_BYTES), '0);
        send_request(KIND_ALLOC, 12'd1, '0);
        free_all();
        send_request(KIND_ALLOC, 12'd1, '0);
        send_request(KIND_ALLOC, 12'd16, '0);
        send_request(KIND_ALLOC, 12'd17, '0);
        send_request(KIND_ALLOC, 12'd100, '0);
        send_request(KIND_FREE, '0, base_reg + 32'd8);
        send_request(KIND_FREE, '0, base_reg + 32'(REGION_BYTES));
        send_request(KIND_FREE, '0, 32'hFFFF_FFFF);
        send_request(KIND_FREE, '0, base_reg + 32'd48);
        send_request(KIND_FREE, '0, live_addrs[1]);
        send_request(KIND_FREE, '0, live_addrs[0]);
        send_request(KIND_FREE, '0, base_reg);
        free_all();
    endtask

    task automatic test_random(int count);
        logic [SIZE_W-1:0] sz;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(9))
                0: send_request(KIND_ALLOC, 12'($urandom), 32'($urandom));
                1: send_request(KIND_FREE, 12'($urandom), 32'($urandom));
                2: send_request(KIND_FREE, '0, base_reg + 32'($urandom_range(REGION_BYTES)));
                3, 4, 5: begin
                    sz = ($urandom_range(3) == 0) ? 12'($urandom_range(REGION_BYTES))
                                                  : 12'($urandom_range(1, 64));
                    send_request(KIND_ALLOC, sz, 32'($urandom));
                end
                default: begin
                    if (live_addrs.size() != 0)
                        send_request(KIND_FREE, 12'($urandom),
                                     live_addrs[$urandom_range(live_addrs.size() - 1)]);
                    else
                        send_request(KIND_ALLOC, 12'($urandom_range(1, 128)), '0);
                end
            endcase
        end
    endtask

    task automatic test_base_settings();
        // release every block while its address is still valid under the old base
        free_all();
        write_base(32'hFFFF_FF00);
        test_directed();
        test_random(120);
        free_all();
        write_base(32'hFFFF_FFFF);
        test_random(60);
        free_all();
        write_base(32'($urandom));
        test_random(100);
        free_all();
        write_base(32'h0000_0000);
    endtask

    initial begin
        model_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 36;
        recv_idle_pct = 81;
        test_directed();
        test_random(150);
        drain();
        send_idle_pct = 81;
        recv_idle_pct = 36;
        test_base_settings();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(230);
        drain();
        if (!failed && pending_results.size() == 0) begin
            $display("PASS binary_buddy_allocator_top");
        end else begin
            $display("FAIL binary_buddy_allocator_top");
        end
        $finish;
    end
endmodule
